// File: sv/depth_edge_map_detector_core_defines.svh
// assertion macros for the depth edge map detector checker
// no dependencies; expects clk and rst_n in the scope of use
`ifndef DEPTH_EDGE_MAP_DETECTOR_CORE_DEFINES_SVH
`define DEPTH_EDGE_MAP_DETECTOR_CORE_DEFINES_SVH

// same-cycle implication
`define DEM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DEM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dem_pkg.sv
// shared types and constants of the depth edge map detector
// no dependencies
package dem_pkg;

  localparam int COORD_BITS  = 24;
  localparam int ROOT_BITS   = 26;
  localparam int SQRT_STAGES = ROOT_BITS / 2;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_RADIUS = 8;

  localparam int FW_BITS = 11;
  localparam int WR_BITS = 4;
  localparam int RT_BITS = 16;

  localparam logic [FW_BITS-1:0] FW_RESET = 11'd640;
  localparam logic [WR_BITS-1:0] WR_RESET = 4'd1;
  localparam logic [RT_BITS-1:0] RT_RESET = 16'd282;

  localparam logic [1:0] REG_FRAME_WIDTH     = 2'd0;
  localparam logic [1:0] REG_WINDOW_RADIUS   = 2'd1;
  localparam logic [1:0] REG_RATIO_THRESHOLD = 2'd2;

  localparam logic [7:0] EDGE_CODE = 8'd255;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic                         frame_start;
  } in_item_t;

  typedef struct packed {
    logic [9:0] out_row;
    logic [9:0] out_col;
    logic       write_map;
    logic [7:0] edge_value;
  } out_item_t;

endpackage

// File: sv/depth_edge_map_detector_core.sv
// depth edge map detector top level: line buffers, window, norm pipeline
// depends on dem_pkg
//
// Takes one point per cycle while in_stall is low and gives the judgement of a
// centre pixel after the pixel that completes its window, via stages 1 to 5,
// the 13-stage square root pipeline and the compare and output registers. The
// line buffers are one memory of 2*MAX_RADIUS+1 rows of MAX_WIDTH points with
// one write and two read ports, so a full throughput of one pixel per cycle is
// kept. in_stall rises only when the output register holds a stalled result
// and the last stage holds one. The line buffers are not cleared; a window
// never reaches unwritten entries while the frame is well formed.
module depth_edge_map_detector_core #(
  parameter int MAX_WIDTH  = dem_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dem_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = dem_pkg::DEF_MAX_RADIUS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dem_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dem_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int CB    = dem_pkg::COORD_BITS;
  localparam int RB    = dem_pkg::ROOT_BITS;
  localparam int SQ    = dem_pkg::SQRT_STAGES;
  localparam int RADB  = 2 * RB;
  localparam int REMB  = RB + 3;
  localparam int NSLOT = 2 * MAX_RADIUS + 1;
  localparam int SLW   = $clog2(NSLOT);
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int CAW   = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int RDW   = $clog2(MAX_RADIUS + 1);
  localparam int WD    = 2 * MAX_RADIUS;
  localparam int WIW   = $clog2(WD);
  localparam int NS    = 4 + SQ;
  localparam int PRW   = dem_pkg::RT_BITS + RB;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
  } pt_t;

  typedef struct packed {
    logic       res;
    logic [9:0] row;
    logic [9:0] col;
    logic       xmiss;
    logic [3:0] skip;
    logic [3:0] force_e;
  } sd_t;

  typedef struct packed {
    logic [RADB-1:0] rad;
    logic [REMB-1:0] rem;
    logic [RB-1:0]   root;
  } sq_t;

  function automatic logic missing(input pt_t p);
    return (p.x == '0) && (p.y == '0) && (p.z == '0);
  endfunction

  function automatic logic signed [CB-1:0] crd(input pt_t p, input int j);
    case (j)
      0:       return p.x;
      1:       return p.y;
      default: return p.z;
    endcase
  endfunction

  function automatic logic [CB-1:0] absdiff(input logic signed [CB-1:0] a,
                                            input logic signed [CB-1:0] b);
    logic signed [CB:0] d;
    logic [CB:0]        nd;
    d  = {a[CB-1], a} - {b[CB-1], b};
    nd = -d;
    return d[CB] ? nd[CB-1:0] : d[CB-1:0];
  endfunction

  function automatic sq_t sq_iter(input sq_t s);
    sq_t             o;
    logic [REMB-1:0] rem2;
    logic [REMB-1:0] trial;
    rem2  = {s.rem[REMB-3:0], s.rad[RADB-1:RADB-2]};
    trial = REMB'({s.root, 2'b01});
    o.rad = {s.rad[RADB-3:0], 2'b00};
    if (rem2 >= trial) begin
      o.rem  = rem2 - trial;
      o.root = {s.root[RB-2:0], 1'b1};
    end else begin
      o.rem  = rem2;
      o.root = {s.root[RB-2:0], 1'b0};
    end
    return o;
  endfunction

  // configuration registers
  logic [dem_pkg::FW_BITS-1:0] frame_width_r;
  logic [dem_pkg::WR_BITS-1:0] window_radius_r;
  logic [dem_pkg::RT_BITS-1:0] ratio_threshold_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r     <= dem_pkg::FW_RESET;
      window_radius_r   <= dem_pkg::WR_RESET;
      ratio_threshold_r <= dem_pkg::RT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        dem_pkg::REG_FRAME_WIDTH:     frame_width_r     <= pwdata[dem_pkg::FW_BITS-1:0];
        dem_pkg::REG_WINDOW_RADIUS:   window_radius_r   <= pwdata[dem_pkg::WR_BITS-1:0];
        dem_pkg::REG_RATIO_THRESHOLD: ratio_threshold_r <= pwdata[dem_pkg::RT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      dem_pkg::REG_FRAME_WIDTH:     prdata = 32'(frame_width_r);
      dem_pkg::REG_WINDOW_RADIUS:   prdata = 32'(window_radius_r);
      dem_pkg::REG_RATIO_THRESHOLD: prdata = 32'(ratio_threshold_r);
      default:                      prdata = '0;
    endcase
  end

  // effective width and radius
  logic [CW-1:0]  w_eff;
  logic [RDW-1:0] r_eff;
  logic [RDW:0]   r2;

  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = CW'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(frame_width_r);
    end
    if (window_radius_r == '0) begin
      r_eff = RDW'(1);
    end else if (32'(window_radius_r) > MAX_RADIUS) begin
      r_eff = RDW'(MAX_RADIUS);
    end else begin
      r_eff = RDW'(window_radius_r);
    end
    r2 = {r_eff, 1'b0};
  end

  // pipeline control
  logic en;
  logic accept;
  sd_t  sd_r [NS];
  logic out_valid_r;
  dem_pkg::out_item_t out_data_r;

  assign en       = !out_valid_r || !out_stall || !sd_r[NS-1].res;
  assign in_stall = !en;
  assign accept   = in_valid && en;

  // raster position
  logic [RW-1:0]  row_r, row_nxt;
  logic [CW-1:0]  col_r, col_nxt, col_pos;
  logic [SLW-1:0] slot_r, slot_nxt, slot_a, slot_b;
  logic           ovf_r, ovf_nxt;
  logic           store, res_new;
  logic [RW-1:0]  cr;
  logic [CW-1:0]  cc;
  pt_t            pix;
  int             ta, tb;

  always_comb begin
    row_nxt  = row_r;
    col_pos  = col_r;
    slot_nxt = slot_r;
    ovf_nxt  = ovf_r;
    if (in_data.frame_start) begin
      row_nxt  = '0;
      col_pos  = '0;
      slot_nxt = '0;
      ovf_nxt  = 1'b0;
    end else if (col_r >= w_eff) begin
      col_pos = '0;
      if (32'(row_r) + 1 >= MAX_HEIGHT) begin
        ovf_nxt = 1'b1;
      end else begin
        row_nxt  = row_r + 1'b1;
        slot_nxt = (slot_r == SLW'(NSLOT - 1)) ? '0 : slot_r + 1'b1;
      end
    end
    store   = !ovf_nxt;
    col_nxt = store ? col_pos + 1'b1 : col_pos;
    res_new = store && (32'(row_nxt) >= 32'(r2)) && (32'(col_pos) >= 32'(r2));
    cr      = row_nxt - RW'(r_eff);
    cc      = col_pos - CW'(r_eff);
    ta      = int'(slot_nxt) - int'(r_eff);
    tb      = int'(slot_nxt) - int'(r2);
    if (ta < 0) ta = ta + NSLOT;
    if (tb < 0) tb = tb + NSLOT;
    slot_a  = SLW'(ta);
    slot_b  = SLW'(tb);
    pix     = '{x: in_data.point_x, y: in_data.point_y, z: in_data.point_z};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
      ovf_r  <= 1'b0;
    end else if (accept) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  // line buffers
  pt_t line_mem_r [NSLOT][MAX_WIDTH];
  pt_t rda_r, rdb_r;

  always_ff @(posedge clk) begin
    if (accept && store) begin
      line_mem_r[slot_nxt][col_pos[CAW-1:0]] <= pix;
    end
    if (en) begin
      rda_r <= line_mem_r[slot_a][col_pos[CAW-1:0]];
      rdb_r <= line_mem_r[slot_b][col_pos[CAW-1:0]];
    end
  end

  // stage 1
  logic       s1_store_r, s1_res_r;
  pt_t        s1_pix_r;
  logic [9:0] s1_row_r, s1_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_store_r <= 1'b0;
      s1_res_r   <= 1'b0;
    end else if (en) begin
      s1_store_r <= accept && store;
      s1_res_r   <= accept && res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pix_r <= pix;
      s1_row_r <= 10'(cr);
      s1_col_r <= 10'(cc);
    end
  end

  // stage 2: column windows of the three rows
  pt_t            win_r [3][WD];
  pt_t            new0 [3];
  pt_t            tr [3];
  pt_t            t2r [3];
  logic [WIW-1:0] ir, i2r;
  logic           s2_res_r;
  logic [9:0]     s2_row_r, s2_col_r;
  pt_t            s2_pa_r [4];
  pt_t            s2_pb_r [4];
  pt_t            s2_px_r;

  always_comb begin
    new0[0] = s1_pix_r;
    new0[1] = rda_r;
    new0[2] = rdb_r;
    ir      = WIW'(int'(r_eff) - 1);
    i2r     = WIW'(int'(r2) - 1);
    for (int l = 0; l < 3; l++) begin
      tr[l]  = win_r[l][ir];
      t2r[l] = win_r[l][i2r];
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_store_r) begin
      for (int l = 0; l < 3; l++) begin
        for (int i = WD - 1; i > 0; i--) begin
          win_r[l][i] <= win_r[l][i-1];
        end
        win_r[l][0] <= new0[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_res_r <= 1'b0;
    end else if (en) begin
      s2_res_r <= s1_res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_row_r   <= s1_row_r;
      s2_col_r   <= s1_col_r;
      s2_pa_r[0] <= t2r[2];
      s2_pb_r[0] <= new0[0];
      s2_pa_r[1] <= tr[2];
      s2_pb_r[1] <= tr[0];
      s2_pa_r[2] <= new0[2];
      s2_pb_r[2] <= t2r[0];
      s2_pa_r[3] <= new0[1];
      s2_pb_r[3] <= t2r[1];
      s2_px_r    <= tr[1];
    end
  end

  // stage 3: missing flags and coordinate differences
  sd_t           sd_nxt;
  logic [CB-1:0] dif_nxt [12][3];
  logic [CB-1:0] dif_r [12][3];

  always_comb begin
    sd_nxt.res   = s2_res_r;
    sd_nxt.row   = s2_row_r;
    sd_nxt.col   = s2_col_r;
    sd_nxt.xmiss = missing(s2_px_r);
    for (int k = 0; k < 4; k++) begin
      sd_nxt.skip[k]    = missing(s2_pa_r[k]) && missing(s2_pb_r[k]);
      sd_nxt.force_e[k] = missing(s2_pa_r[k]) ^ missing(s2_pb_r[k]);
      for (int j = 0; j < 3; j++) begin
        dif_nxt[3*k][j]   = absdiff(crd(s2_pa_r[k], j), crd(s2_px_r, j));
        dif_nxt[3*k+1][j] = absdiff(crd(s2_pb_r[k], j), crd(s2_px_r, j));
        dif_nxt[3*k+2][j] = absdiff(crd(s2_pa_r[k], j), crd(s2_pb_r[k], j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) begin
        sd_r[s].res <= 1'b0;
      end
    end else if (en) begin
      sd_r[0] <= sd_nxt;
      for (int s = 1; s < NS; s++) begin
        sd_r[s] <= sd_r[s-1];
      end
    end
  end

  // stages 4 and 5: squares and sums, then square root stages
  logic [2*CB-1:0] sqr_r [12][3];
  sq_t             sq_r [SQ+1][12];
  logic [RB+8:0]   lhs_r [4];
  logic [PRW-1:0]  rhs_r [4];
  logic [RB:0]     sab [4];
  logic [RB-1:0]   amb [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sab[k] = (RB+1)'(sq_r[SQ][3*k].root) + (RB+1)'(sq_r[SQ][3*k+1].root);
      amb[k] = (sq_r[SQ][3*k+2].root == '0) ? RB'(1) : sq_r[SQ][3*k+2].root;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 12; n++) begin
        dif_r[n] <= dif_nxt[n];
        for (int j = 0; j < 3; j++) begin
          sqr_r[n][j] <= (2*CB)'(dif_r[n][j]) * (2*CB)'(dif_r[n][j]);
        end
        sq_r[0][n].rad  <= RADB'(sqr_r[n][0]) + RADB'(sqr_r[n][1]) + RADB'(sqr_r[n][2]);
        sq_r[0][n].rem  <= '0;
        sq_r[0][n].root <= '0;
        for (int s = 1; s <= SQ; s++) begin
          sq_r[s][n] <= sq_iter(sq_iter(sq_r[s-1][n]));
        end
      end
      for (int k = 0; k < 4; k++) begin
        lhs_r[k] <= {sab[k], 8'b0};
        rhs_r[k] <= PRW'(ratio_threshold_r) * PRW'(amb[k]);
      end
    end
  end

  // compare and output register
  logic edge_hit;

  always_comb begin
    edge_hit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (sd_r[NS-1].force_e[k]) begin
        edge_hit = 1'b1;
      end else if (!sd_r[NS-1].skip[k] && (PRW'(lhs_r[k]) > rhs_r[k])) begin
        edge_hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && sd_r[NS-1].res) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && sd_r[NS-1].res) begin
      out_data_r.out_row    <= sd_r[NS-1].row;
      out_data_r.out_col    <= sd_r[NS-1].col;
      out_data_r.write_map  <= !sd_r[NS-1].xmiss;
      out_data_r.edge_value <= (!sd_r[NS-1].xmiss && edge_hit) ? dem_pkg::EDGE_CODE : 8'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/dem_chk.sv
// port-level checker for the depth edge map detector, bound to the top level
// depends on dem_pkg and the assertion macro header
`include "depth_edge_map_detector_core_defines.svh"

module dem_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input dem_pkg::out_item_t out_data
);

  `DEM_ASSERT_IMP(a_idle_out_no_stall, !out_valid, !in_stall, "input stalled with empty output")
  `DEM_ASSERT_IMP(a_nowrite_zero, out_valid && !out_data.write_map, out_data.edge_value == 8'd0, "edge value set without map write")
  `DEM_ASSERT_IMP(a_edge_code, out_valid, out_data.edge_value == 8'd0 || out_data.edge_value == dem_pkg::EDGE_CODE, "bad edge value")
  `DEM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind depth_edge_map_detector_core dem_chk u_dem_chk (.*);
